FILE: rtl/ecss_pkg.sv
package ecss_pkg;

  // operand width of every modulus, coordinate and scalar
  localparam int unsigned W  = 16;
  localparam int unsigned CW = $clog2(W);

  // configuration register indexes
  localparam logic [1:0] CFG_FIELD_PRIME = 2'd0;
  localparam logic [1:0] CFG_COEFF_A     = 2'd1;
  localparam logic [1:0] CFG_GROUP_ORDER = 2'd2;

  // result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RZERO = 2'd1;
  localparam logic [1:0] ST_SZERO = 2'd2;
  localparam logic [1:0] ST_NOINV = 2'd3;

  // operations of the shared arithmetic unit
  typedef enum logic [1:0] {
    OP_MUL = 2'd0,
    OP_DIV = 2'd1,
    OP_INV = 2'd2
  } ar_op_e;

  typedef struct packed {
    logic [W-1:0] base_x;
    logic [W-1:0] base_y;
    logic [W-1:0] private_key;
    logic [W-1:0] message;
    logic [W-1:0] nonce;
  } in_t;

  typedef struct packed {
    logic [W-1:0] sig_r;
    logic [W-1:0] sig_s;
    logic [1:0]   status;
  } out_t;

  // request from the sequencer to the arithmetic unit
  typedef struct packed {
    logic         start;
    ar_op_e       op;
    logic [W-1:0] a;
    logic [W-1:0] b;
    logic [W-1:0] m;
  } ar_req_t;

  // modular add, both operands below m
  function automatic logic [W-1:0] addm(input logic [W-1:0] a, input logic [W-1:0] b,
                                        input logic [W-1:0] m);
    logic [W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, m}) s = s - {1'b0, m};
    return s[W-1:0];
  endfunction

  // modular subtract, both operands below m
  function automatic logic [W-1:0] subm(input logic [W-1:0] a, input logic [W-1:0] b,
                                        input logic [W-1:0] m);
    logic [W:0] s;
    if (a >= b) s = {1'b0, a} - {1'b0, b};
    else        s = {1'b0, a} + {1'b0, m} - {1'b0, b};
    return s[W-1:0];
  endfunction

endpackage

FILE: rtl/ecss_arith.sv
module ecss_arith (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  ecss_pkg::ar_req_t       req_i,
  output logic                    done_o,
  output logic [ecss_pkg::W-1:0]  res_o,
  output logic                    ok_o
);
  import ecss_pkg::*;

  localparam logic [2:0] A_IDLE   = 3'd0;
  localparam logic [2:0] A_MUL    = 3'd1;
  localparam logic [2:0] A_DIV    = 3'd2;
  localparam logic [2:0] A_INVCHK = 3'd3;
  localparam logic [2:0] A_INVDIV = 3'd4;
  localparam logic [2:0] A_INVMUL = 3'd5;

  localparam logic [CW-1:0] LAST = CW'(W - 1);

  logic [2:0]    st_q;
  logic [CW-1:0] cnt_q;
  logic [W-1:0]  acc_q, a_q, b_q, m_q;
  logic [W-1:0]  r0_q, r1_q, t0_q, t1_q, nr_q;
  logic [W-1:0]  res_q;
  logic          ok_q, done_q;

  logic [W:0]    dbl, d1, addv, mul_w, trial;
  logic [W-1:0]  mul_nx, div_rem, div_quo, qt_red;
  logic          ge;

  // one bit-serial step: double-and-add multiply, restoring divide
  always_comb begin
    dbl     = {acc_q, 1'b0};
    d1      = (dbl >= {1'b0, m_q}) ? dbl - {1'b0, m_q} : dbl;
    addv    = d1 + (b_q[W-1] ? {1'b0, a_q} : '0);
    mul_w   = (addv >= {1'b0, m_q}) ? addv - {1'b0, m_q} : addv;
    mul_nx  = mul_w[W-1:0];
    trial   = {acc_q, b_q[W-1]};
    ge      = trial >= {1'b0, a_q};
    div_rem = ge ? W'(trial - {1'b0, a_q}) : trial[W-1:0];
    div_quo = {b_q[W-2:0], ge};
    qt_red  = (div_quo >= m_q) ? div_quo - m_q : div_quo;
  end

  // sequencer of the unit: multiply, divide and extended euclid inverse
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= A_IDLE;
      done_q <= 1'b0;
      cnt_q  <= '0;
      acc_q  <= '0;
      a_q    <= '0;
      b_q    <= '0;
      m_q    <= '0;
      r0_q   <= '0;
      r1_q   <= '0;
      t0_q   <= '0;
      t1_q   <= '0;
      nr_q   <= '0;
      res_q  <= '0;
      ok_q   <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (st_q)
        A_IDLE: begin
          if (req_i.start) begin
            m_q   <= req_i.m;
            acc_q <= '0;
            cnt_q <= '0;
            ok_q  <= 1'b1;
            case (req_i.op)
              OP_MUL: begin
                a_q  <= req_i.a;
                b_q  <= req_i.b;
                st_q <= A_MUL;
              end
              OP_DIV: begin
                a_q  <= req_i.b;
                b_q  <= req_i.a;
                st_q <= A_DIV;
              end
              OP_INV: begin
                r0_q <= req_i.m;
                r1_q <= req_i.a;
                t0_q <= '0;
                t1_q <= (req_i.m == W'(1)) ? '0 : W'(1);
                st_q <= A_INVCHK;
              end
              default: st_q <= A_IDLE;
            endcase
          end
        end
        A_MUL: begin
          acc_q <= mul_nx;
          b_q   <= b_q << 1;
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == LAST) begin
            res_q  <= mul_nx;
            done_q <= 1'b1;
            st_q   <= A_IDLE;
          end
        end
        A_DIV: begin
          acc_q <= div_rem;
          b_q   <= div_quo;
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == LAST) begin
            res_q  <= div_rem;
            done_q <= 1'b1;
            st_q   <= A_IDLE;
          end
        end
        A_INVCHK: begin
          if (r1_q == '0) begin
            res_q  <= t0_q;
            ok_q   <= (r0_q == W'(1));
            done_q <= 1'b1;
            st_q   <= A_IDLE;
          end else begin
            acc_q <= '0;
            b_q   <= r0_q;
            a_q   <= r1_q;
            cnt_q <= '0;
            st_q  <= A_INVDIV;
          end
        end
        A_INVDIV: begin
          acc_q <= div_rem;
          b_q   <= div_quo;
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == LAST) begin
            // quotient times t1, quotient reduced below the modulus
            nr_q  <= div_rem;
            b_q   <= qt_red;
            a_q   <= t1_q;
            acc_q <= '0;
            cnt_q <= '0;
            st_q  <= A_INVMUL;
          end
        end
        A_INVMUL: begin
          acc_q <= mul_nx;
          b_q   <= b_q << 1;
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == LAST) begin
            r0_q <= r1_q;
            r1_q <= nr_q;
            t0_q <= t1_q;
            t1_q <= subm(t0_q, mul_nx, m_q);
            st_q <= A_INVCHK;
          end
        end
        default: st_q <= A_IDLE;
      endcase
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;
  assign ok_o   = ok_q;

endmodule

FILE: rtl/ec_signature_sign.sv
// One signature per transaction: r is the x coordinate of nonce times the base
// point mod group_order, s is nonce^-1 * (2^message + key * r) mod group_order,
// and status flags an infinite point or zero r (1), a non-invertible nonce (3)
// and a zero s (2). Every modular multiply, reduction and inverse runs on one
// shared bit-serial unit. A multiply or divide is 16 bit steps, and the
// sequencer takes each result up from a wait state. A point addition or
// doubling that is not a trivial case needs an extended euclid inverse, with
// one division and one multiply per round. The time an item takes is set by
// the number of nonce and message bits and by the inverse lengths. in_stall_o
// stays high from acceptance until the result transaction leaves the output
// register. Configuration writes are taken at any time but belong in idle.
module ec_signature_sign (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [15:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  ecss_pkg::in_t      in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output ecss_pkg::out_t     out_data_o
);
  import ecss_pkg::*;

  localparam logic [5:0] S_IDLE = 6'd0;
  localparam logic [5:0] S_WAIT = 6'd1;
  localparam logic [5:0] S_A0   = 6'd2;
  localparam logic [5:0] S_A1   = 6'd3;
  localparam logic [5:0] S_A2   = 6'd4;
  localparam logic [5:0] S_A3   = 6'd5;
  localparam logic [5:0] S_A4   = 6'd6;
  localparam logic [5:0] S_LOOP = 6'd7;
  localparam logic [5:0] S_DBL  = 6'd8;
  localparam logic [5:0] S_PRET = 6'd9;
  localparam logic [5:0] S_PA0  = 6'd10;
  localparam logic [5:0] S_PD1  = 6'd11;
  localparam logic [5:0] S_PD2  = 6'd12;
  localparam logic [5:0] S_PI   = 6'd13;
  localparam logic [5:0] S_PL   = 6'd14;
  localparam logic [5:0] S_PX   = 6'd15;
  localparam logic [5:0] S_PX2  = 6'd16;
  localparam logic [5:0] S_PY   = 6'd17;
  localparam logic [5:0] S_PY2  = 6'd18;
  localparam logic [5:0] S_R0   = 6'd19;
  localparam logic [5:0] S_R1   = 6'd20;
  localparam logic [5:0] S_H0   = 6'd21;
  localparam logic [5:0] S_HL   = 6'd22;
  localparam logic [5:0] S_HB1  = 6'd23;
  localparam logic [5:0] S_HB   = 6'd24;
  localparam logic [5:0] S_HB2  = 6'd25;
  localparam logic [5:0] S_K0   = 6'd26;
  localparam logic [5:0] S_K1   = 6'd27;
  localparam logic [5:0] S_K2   = 6'd28;
  localparam logic [5:0] S_K3   = 6'd29;
  localparam logic [5:0] S_K4   = 6'd30;
  localparam logic [5:0] S_K5   = 6'd31;
  localparam logic [5:0] S_OUT  = 6'd32;

  // configuration registers
  logic [W-1:0] fp_q, ca_q, go_q;

  // sequencer state
  logic [5:0]   st_q, nxt_q;
  logic         ret_acc_q;

  // operands of the current transaction
  logic [W-1:0] p_q, q_q, a_q, key_q, msg_q, k_q, n_q, bx_q, by_q, pk_q;
  logic [W-1:0] tx_q, ty_q, ax_q, ay_q;
  logic         t_inf_q, a_inf_q;

  // point addition operands and result
  logic [W-1:0] x1_q, y1_q, x2_q, y2_q, rx_q, ry_q, num_q, den_q, lam_q;
  logic         i1_q, i2_q, rinf_q;

  // scalar side
  logic [W-1:0] r_q, h_q, base_q, kinv_q;
  logic         kok_q;

  // output register
  logic         ov_q;
  out_t         od_q;

  ar_req_t      req;
  logic         ar_done, ar_ok;
  logic [W-1:0] ar_res;
  logic [W-1:0] three_p;
  logic [1:0]   status;

  ecss_arith u_arith (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .done_o (ar_done),
    .res_o  (ar_res),
    .ok_o   (ar_ok)
  );

  // 3 mod p for the doubling slope
  always_comb begin
    case (p_q)
      W'(1):   three_p = '0;
      W'(2):   three_p = W'(1);
      W'(3):   three_p = '0;
      default: three_p = W'(3);
    endcase
  end

  // result status, infinite point or zero r first
  always_comb begin
    if (a_inf_q || r_q == '0) status = ST_RZERO;
    else if (!kok_q)          status = ST_NOINV;
    else if (ar_res == '0)    status = ST_SZERO;
    else                      status = ST_OK;
  end

  // request to the shared unit, issued for one cycle
  always_comb begin
    req       = '0;
    req.op    = OP_MUL;
    case (st_q)
      S_A0: begin req.start = 1'b1; req.op = OP_DIV; req.a = ca_q; req.b = p_q; end
      S_A1: begin req.start = 1'b1; req.op = OP_DIV; req.a = bx_q; req.b = p_q; end
      S_A2: begin req.start = 1'b1; req.op = OP_DIV; req.a = by_q; req.b = p_q; end
      S_A3: begin req.start = 1'b1; req.op = OP_DIV; req.a = pk_q; req.b = q_q; end
      S_PA0: begin
        req.a = x1_q; req.b = x1_q; req.m = p_q;
        req.start = !i1_q && !i2_q && (x1_q == x2_q) && (y1_q == y2_q) && (y1_q != '0);
      end
      S_PD1: begin req.start = 1'b1; req.a = three_p; req.b = ar_res; req.m = p_q; end
      S_PI:  begin req.start = 1'b1; req.op = OP_INV; req.a = den_q; req.m = p_q; end
      S_PL:  begin req.start = ar_ok; req.a = num_q; req.b = ar_res; req.m = p_q; end
      S_PX:  begin req.start = 1'b1; req.a = ar_res; req.b = ar_res; req.m = p_q; end
      S_PY:  begin
        req.start = 1'b1; req.a = lam_q; req.b = subm(x1_q, rx_q, p_q); req.m = p_q;
      end
      S_R0:  begin req.start = !a_inf_q; req.op = OP_DIV; req.a = ax_q; req.b = q_q; end
      S_HL:  begin
        req.start = (msg_q != '0) && msg_q[0]; req.a = h_q; req.b = base_q; req.m = q_q;
      end
      S_HB:  begin req.start = 1'b1; req.a = base_q; req.b = base_q; req.m = q_q; end
      S_K0:  begin req.start = 1'b1; req.op = OP_DIV; req.a = k_q; req.b = q_q; end
      S_K1:  begin req.start = 1'b1; req.op = OP_INV; req.a = ar_res; req.m = q_q; end
      S_K2:  begin req.start = 1'b1; req.a = key_q; req.b = r_q; req.m = q_q; end
      S_K4:  begin req.start = 1'b1; req.a = kinv_q; req.b = h_q; req.m = q_q; end
      default: req.start = 1'b0;
    endcase
  end

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fp_q <= W'(11);
      ca_q <= W'(1);
      go_q <= W'(13);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_FIELD_PRIME: fp_q <= cfg_data_i;
        CFG_COEFF_A:     ca_q <= cfg_data_i;
        CFG_GROUP_ORDER: go_q <= cfg_data_i;
        default:         ;
      endcase
    end
  end

  // main sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= S_IDLE;
      nxt_q     <= S_IDLE;
      ov_q      <= 1'b0;
      ret_acc_q <= 1'b0;
      od_q      <= '0;
      {p_q, q_q, a_q, key_q, msg_q, k_q, n_q, bx_q, by_q, pk_q} <= '0;
      {tx_q, ty_q, ax_q, ay_q, t_inf_q, a_inf_q} <= '0;
      {x1_q, y1_q, x2_q, y2_q, rx_q, ry_q, num_q, den_q, lam_q} <= '0;
      {i1_q, i2_q, rinf_q} <= '0;
      {r_q, h_q, base_q, kinv_q, kok_q} <= '0;
    end else begin
      case (st_q)
        S_IDLE: begin
          if (in_valid_i) begin
            p_q   <= (fp_q < W'(2)) ? W'(1) : fp_q;
            q_q   <= (go_q < W'(2)) ? W'(1) : go_q;
            bx_q  <= in_data_i.base_x;
            by_q  <= in_data_i.base_y;
            pk_q  <= in_data_i.private_key;
            msg_q <= in_data_i.message;
            k_q   <= in_data_i.nonce;
            st_q  <= S_A0;
          end
        end
        S_WAIT: if (ar_done) st_q <= nxt_q;
        // reduce coefficient, base point and key
        S_A0: begin nxt_q <= S_A1; st_q <= S_WAIT; end
        S_A1: begin a_q <= ar_res; nxt_q <= S_A2; st_q <= S_WAIT; end
        S_A2: begin tx_q <= ar_res; nxt_q <= S_A3; st_q <= S_WAIT; end
        S_A3: begin ty_q <= ar_res; nxt_q <= S_A4; st_q <= S_WAIT; end
        S_A4: begin
          key_q   <= ar_res;
          t_inf_q <= 1'b0;
          a_inf_q <= 1'b1;
          n_q     <= k_q;
          st_q    <= S_LOOP;
        end
        // double-and-add from the low nonce bit
        S_LOOP: begin
          if (n_q == '0) begin
            st_q <= S_R0;
          end else if (n_q[0]) begin
            {x1_q, y1_q, i1_q} <= {ax_q, ay_q, a_inf_q};
            {x2_q, y2_q, i2_q} <= {tx_q, ty_q, t_inf_q};
            ret_acc_q <= 1'b1;
            st_q      <= S_PA0;
          end else begin
            st_q <= S_DBL;
          end
        end
        S_DBL: begin
          {x1_q, y1_q, i1_q} <= {tx_q, ty_q, t_inf_q};
          {x2_q, y2_q, i2_q} <= {tx_q, ty_q, t_inf_q};
          ret_acc_q <= 1'b0;
          st_q      <= S_PA0;
        end
        S_PRET: begin
          if (ret_acc_q) begin
            {ax_q, ay_q, a_inf_q} <= {rx_q, ry_q, rinf_q};
            st_q <= S_DBL;
          end else begin
            {tx_q, ty_q, t_inf_q} <= {rx_q, ry_q, rinf_q};
            n_q  <= n_q >> 1;
            st_q <= S_LOOP;
          end
        end
        // point addition or doubling
        S_PA0: begin
          if (i1_q) begin
            {rx_q, ry_q, rinf_q} <= {x2_q, y2_q, i2_q};
            st_q <= S_PRET;
          end else if (i2_q) begin
            {rx_q, ry_q, rinf_q} <= {x1_q, y1_q, i1_q};
            st_q <= S_PRET;
          end else if (x1_q == x2_q) begin
            if (y1_q != y2_q || y1_q == '0) begin
              rinf_q <= 1'b1;
              st_q   <= S_PRET;
            end else begin
              nxt_q <= S_PD1;
              st_q  <= S_WAIT;
            end
          end else begin
            num_q <= subm(y2_q, y1_q, p_q);
            den_q <= subm(x2_q, x1_q, p_q);
            st_q  <= S_PI;
          end
        end
        S_PD1: begin nxt_q <= S_PD2; st_q <= S_WAIT; end
        S_PD2: begin
          num_q <= addm(ar_res, a_q, p_q);
          den_q <= addm(y1_q, y1_q, p_q);
          st_q  <= S_PI;
        end
        S_PI: begin nxt_q <= S_PL; st_q <= S_WAIT; end
        S_PL: begin
          if (!ar_ok) begin
            rinf_q <= 1'b1;
            st_q   <= S_PRET;
          end else begin
            nxt_q <= S_PX;
            st_q  <= S_WAIT;
          end
        end
        S_PX: begin lam_q <= ar_res; nxt_q <= S_PX2; st_q <= S_WAIT; end
        S_PX2: begin
          rx_q <= subm(subm(ar_res, x1_q, p_q), x2_q, p_q);
          st_q <= S_PY;
        end
        S_PY: begin nxt_q <= S_PY2; st_q <= S_WAIT; end
        S_PY2: begin
          ry_q   <= subm(ar_res, y1_q, p_q);
          rinf_q <= 1'b0;
          st_q   <= S_PRET;
        end
        // r from the x coordinate
        S_R0: begin
          if (a_inf_q) begin
            r_q  <= '0;
            st_q <= S_H0;
          end else begin
            nxt_q <= S_R1;
            st_q  <= S_WAIT;
          end
        end
        S_R1: begin r_q <= ar_res; st_q <= S_H0; end
        // hash as a power of two by square-and-multiply
        S_H0: begin
          h_q    <= (q_q == W'(1)) ? '0 : W'(1);
          base_q <= (q_q == W'(1) || q_q == W'(2)) ? '0 : W'(2);
          st_q   <= S_HL;
        end
        S_HL: begin
          if (msg_q == '0) begin
            st_q <= S_K0;
          end else if (msg_q[0]) begin
            nxt_q <= S_HB1;
            st_q  <= S_WAIT;
          end else begin
            st_q <= S_HB;
          end
        end
        S_HB1: begin h_q <= ar_res; st_q <= S_HB; end
        S_HB:  begin nxt_q <= S_HB2; st_q <= S_WAIT; end
        S_HB2: begin
          base_q <= ar_res;
          msg_q  <= msg_q >> 1;
          st_q   <= S_HL;
        end
        // nonce inverse and s
        S_K0: begin nxt_q <= S_K1; st_q <= S_WAIT; end
        S_K1: begin nxt_q <= S_K2; st_q <= S_WAIT; end
        S_K2: begin
          kinv_q <= ar_ok ? ar_res : '0;
          kok_q  <= ar_ok;
          nxt_q  <= S_K3;
          st_q   <= S_WAIT;
        end
        S_K3: begin h_q <= addm(h_q, ar_res, q_q); st_q <= S_K4; end
        S_K4: begin nxt_q <= S_K5; st_q <= S_WAIT; end
        S_K5: begin
          od_q.sig_r  <= r_q;
          od_q.sig_s  <= ar_res;
          od_q.status <= status;
          ov_q        <= 1'b1;
          st_q        <= S_OUT;
        end
        S_OUT: begin
          if (!out_stall_i) begin
            ov_q <= 1'b0;
            st_q <= S_IDLE;
          end
        end
        default: st_q <= S_IDLE;
      endcase
    end
  end

  assign in_stall_o  = (st_q != S_IDLE);
  assign out_valid_o = ov_q;
  assign out_data_o  = od_q;

endmodule

FILE: rtl/ecss_checker.sv
module ecss_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input ecss_pkg::out_t     out_data_o
);
  import ecss_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  // no new transaction while a result waits
  a_busy_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input open while result pending");

  // an accepted transaction never yields a result in the next cycle
  a_no_early: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> !out_valid_o)
    else $error("result too early");

  // zero r exactly when flagged
  a_r_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((out_data_o.sig_r == '0) == (out_data_o.status == ST_RZERO)))
    else $error("r and status disagree");

  // zero s flagged or non-invertible nonce gives zero s
  a_s_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status == ST_SZERO || out_data_o.status == ST_NOINV)
    |-> out_data_o.sig_s == '0)
    else $error("s flag with non-zero s");

endmodule

bind ec_signature_sign ecss_checker u_ecss_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

FILE: bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import ecss_pkg::*;

  logic         clk_i;
  logic         rst_ni;
  logic         cfg_we_i;
  logic [1:0]   cfg_idx_i;
  logic [15:0]  cfg_data_i;
  logic         in_valid_i;
  logic         in_stall_o;
  in_t          in_data_i;
  logic         out_valid_o;
  logic         out_stall_i;
  out_t         out_data_o;

  // predictor copy of the configuration
  logic [15:0] prime_q, coeff_q, order_q;

  out_t        sig_queue[$];
  int          err_count;
  int          sig_count;
  int          item_count;
  longint      cycle_count;
  bit          idle_on;
  bit          sent_any;

  ec_signature_sign DUT (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_stall_o, .in_data_i,
    .out_valid_o, .out_stall_i, .out_data_o
  );

  // clock
  always begin
    clk_i = 1'b1; #6;
    clk_i = 1'b0; #6;
  end

  // arithmetic helpers for the predictor
  function automatic longint unsigned mod_mul(longint unsigned a, longint unsigned b,
                                              longint unsigned m);
    return ((a % m) * (b % m)) % m;
  endfunction

  function automatic bit mod_inv(longint unsigned a, longint unsigned m,
                                 output longint unsigned inv);
    longint r0, r1, t0, t1, qt, nr, nt;
    r0 = m; r1 = a % m; t0 = 0; t1 = 1 % m;
    while (r1 != 0) begin
      qt = r0 / r1;
      nr = r0 - qt * r1;
      nt = (t0 - longint'(mod_mul(qt, t1, m)));
      if (nt < 0) nt += m;
      r0 = r1; r1 = nr; t0 = t1; t1 = nt;
    end
    inv = t0;
    return r0 == 1;
  endfunction

  typedef struct {
    longint unsigned x;
    longint unsigned y;
    bit              inf;
  } point_t;

  function automatic point_t curve_sum(point_t p1, point_t p2, longint unsigned p,
                                       longint unsigned a);
    point_t res;
    longint unsigned num, den, inv, lam, x3, y3;
    res.inf = 1'b1; res.x = 0; res.y = 0;
    if (p1.inf) return p2;
    if (p2.inf) return p1;
    if (p1.x == p2.x) begin
      if (p1.y != p2.y || p1.y == 0) return res;
      num = (mod_mul(3 % p, mod_mul(p1.x, p1.x, p), p) + a) % p;
      den = (p1.y + p1.y) % p;
    end else begin
      num = (p2.y + p - p1.y) % p;
      den = (p2.x + p - p1.x) % p;
    end
    if (!mod_inv(den, p, inv)) return res;
    lam = mod_mul(num, inv, p);
    x3 = (mod_mul(lam, lam, p) + 2 * p - p1.x - p2.x) % p;
    y3 = (mod_mul(lam, (p1.x + p - x3) % p, p) + p - p1.y) % p;
    res.x = x3; res.y = y3; res.inf = 1'b0;
    return res;
  endfunction

  // expected signature of one transaction
  function automatic out_t sign_predict(in_t it);
    longint unsigned p, q, a, key, msg, n, r, h, b2, kinv, s;
    point_t acc, t;
    bit kok;
    out_t res;
    p = (prime_q < 2) ? 1 : prime_q;
    q = (order_q < 2) ? 1 : order_q;
    a = coeff_q % p;
    key = it.private_key % q;
    msg = it.message;
    n = it.nonce;
    acc.inf = 1'b1; acc.x = 0; acc.y = 0;
    t.x = it.base_x % p; t.y = it.base_y % p; t.inf = 1'b0;
    while (n != 0) begin
      if (n & 1) acc = curve_sum(acc, t, p, a);
      t = curve_sum(t, t, p, a);
      n >>= 1;
    end
    r = acc.inf ? 0 : acc.x % q;
    h = 1 % q; b2 = 2 % q;
    while (msg != 0) begin
      if (msg & 1) h = mod_mul(h, b2, q);
      b2 = mod_mul(b2, b2, q);
      msg >>= 1;
    end
    kok = mod_inv(it.nonce % q, q, kinv);
    if (!kok) kinv = 0;
    s = mod_mul(kinv, (h + mod_mul(key, r, q)) % q, q);
    if (acc.inf || r == 0) res.status = ST_RZERO;
    else if (!kok)         res.status = ST_NOINV;
    else if (s == 0)       res.status = ST_SZERO;
    else                   res.status = ST_OK;
    res.sig_r = r[15:0];
    res.sig_s = s[15:0];
    return res;
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned exp_v);
    $display("mismatch %s: got %0d expected %0d (result %0d)", what, got, exp_v,
             sig_count);
    err_count++;
  endtask

  // result checker with random stalls
  initial begin
    int burst;
    out_t want;
    out_stall_i = 1'b0;
    burst = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) begin
        if (sig_queue.size() == 0) begin
          report_mismatch("unexpected result, sig_r", out_data_o.sig_r, 0);
        end else begin
          want = sig_queue.pop_front();
          if (out_data_o.sig_r !== want.sig_r)
            report_mismatch("sig_r", out_data_o.sig_r, want.sig_r);
          if (out_data_o.sig_s !== want.sig_s)
            report_mismatch("sig_s", out_data_o.sig_s, want.sig_s);
          if (out_data_o.status !== want.status)
            report_mismatch("status", out_data_o.status, want.status);
        end
        sig_count++;
      end
      if (burst > 0) begin
        burst--;
        out_stall_i <= (burst > 0);
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        burst = $urandom_range(1, 19);
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // cycle limit
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > 40_000_000) begin
      $display("timeout");
      $display("== FAIL ==");
      $finish;
    end
  end

  // one register write; the caller lowers the write enable afterwards
  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    case (idx)
      CFG_FIELD_PRIME: prime_q = val;
      CFG_COEFF_A:     coeff_q = val;
      default:         order_q = val;
    endcase
  endtask

  task automatic drain;
    in_valid_i <= 1'b0;
    while (sig_queue.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
  endtask

  task automatic set_curve(logic [15:0] p, logic [15:0] a, logic [15:0] q);
    drain();
    write_reg(CFG_FIELD_PRIME, p);
    write_reg(CFG_COEFF_A, a);
    write_reg(CFG_GROUP_ORDER, q);
    cfg_we_i <= 1'b0;
  endtask

  // send one transaction, with an optional idle burst first
  task automatic send_sig(in_t it);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    sig_queue.push_back(sign_predict(it));
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    item_count++;
  endtask

  function automatic in_t mk(int unsigned bx, int unsigned by, int unsigned key,
                             int unsigned msg, int unsigned k);
    in_t it;
    it.base_x = 16'(bx); it.base_y = 16'(by); it.private_key = 16'(key);
    it.message = 16'(msg); it.nonce = 16'(k);
    return it;
  endfunction

  function automatic in_t rand_item(int unsigned lim, int unsigned kbits);
    return mk($urandom_range(0, lim), $urandom_range(0, lim), $urandom(),
              $urandom(), $urandom_range(1, (1 << kbits) - 1));
  endfunction

  // directed corners on the reset curve
  task automatic test_directed;
    send_sig(mk(2, 4, 3, 0, 1));           // plain point
    send_sig(mk(0, 0, 0, 0, 2));           // doubling with y zero
    send_sig(mk(2, 4, 5, 7, 13));          // nonce equal to order, not invertible
    send_sig(mk(2, 4, 5, 7, 26));
    send_sig(mk(2, 4, 0, 0, 0));           // zero nonce gives infinity
    send_sig(mk(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    send_sig(mk(13, 15, 16'hFFFF, 0, 16'hAAAA)); // coordinates above prime
    send_sig(mk(2, 7, 1, 1, 3));           // inverse points on the way
    send_sig(mk(3, 5, 2, 3, 16'h5555));
    for (int i = 1; i <= 12; i++) send_sig(mk(2, 4, i, i, i));
  endtask

  // degenerate moduli: zero, one, not prime
  task automatic test_moduli;
    set_curve(0, 0, 1);
    send_sig(mk(1, 2, 3, 4, 5));
    send_sig(mk(16'hFFFF, 0, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    set_curve(1, 16'hFFFF, 0);
    send_sig(mk(7, 9, 3, 4, 6));
    set_curve(15, 3, 16);
    for (int i = 0; i < 6; i++) send_sig(rand_item(20, 6));
  endtask

  // random items on several curves, large moduli included
  task automatic test_random(logic [15:0] p, logic [15:0] a, logic [15:0] q,
                             int n, int kbits);
    set_curve(p, a, q);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) == 0) send_sig(rand_item(16'hFFFF, 16));
      else send_sig(rand_item(p + 2, kbits));
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0; cfg_idx_i = CFG_FIELD_PRIME; cfg_data_i = '0;
    in_valid_i = 1'b0; in_data_i = '0;
    prime_q = 11; coeff_q = 1; order_q = 13;
    err_count = 0; sig_count = 0; item_count = 0; cycle_count = 0;
    idle_on = 1'b1;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_moduli();
    test_random(11, 1, 13, 25, 8);
    test_random(97, 2, 89, 25, 10);
    test_random(16'hFFF1, 16'hFFFF, 16'hFFFB, 10, 16);
    test_random(65521, 0, 65519, 10, 12);
    idle_on = 1'b0;
    test_random(23, 1, 29, 50, 8);

    drain();
    repeat (200) @(posedge clk_i);
    $display("sent %0d signature requests over 9 curve settings, checked %0d results",
             item_count, sig_count);
    $display("covered degenerate moduli, infinity, non-invertible nonces, full-width inputs");
    if (err_count == 0 && sig_queue.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/ecss_pkg.sv
rtl/ecss_arith.sv
rtl/ec_signature_sign.sv
rtl/ecss_checker.sv
bench/tb_top.sv
